/* hdl/epoch_seconds_calendar_convert_defines.svh */
// Assertion macros shared by the calendar converter RTL.
`ifndef EPOCH_SECONDS_CALENDAR_CONVERT_DEFINES_SVH
`define EPOCH_SECONDS_CALENDAR_CONVERT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/esc_pkg.sv */
// Shared types, constants and tables of the calendar converter.
package esc_pkg;

  localparam int NumStages       = 8;
  localparam int SecondsWidthDef = 32;
  localparam int DaysW           = 16;

  typedef logic [NumStages-1:0] stage_en_t;

  typedef enum logic [1:0] {
    OP_FROM_SECONDS = 2'd0,
    OP_FROM_DATE    = 2'd1,
    OP_FROM_YDAY    = 2'd2
  } op_e;

  // First day of each month, counted from March 1st (month 0 = March).
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

/* hdl/epoch_seconds_calendar_convert.sv */
// Top level of the epoch-seconds / calendar converter.
// Throughput one request per cycle while a stalled output has not backed up to the input.
// Eight register stages, each with its own valid bit; a stalled output holds a stage
// only while that stage is full and the stage after it holds as well.
// Reset (rst_ni, async, active low) clears the stage valid bits only.
`include "epoch_seconds_calendar_convert_defines.svh"
module epoch_seconds_calendar_convert #(
  parameter int SECONDS_WIDTH = esc_pkg::SecondsWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] seconds_in_i,
  input  logic [4:0]  day_in_i,
  input  logic [3:0]  month_in_i,
  input  logic [11:0] year_in_i,
  input  logic [8:0]  doy_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] seconds_o,
  output logic [21:0] julian_day_o,
  output logic [16:0] second_of_day_o,
  output logic [8:0]  day_of_year_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_o,
  output logic [11:0] year_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  weekday_o,
  output logic        range_error_o
);
  import esc_pkg::*;

  stage_en_t        en;
  logic [DaysW-1:0] days;
  logic             dc_err, from_sec, ck_err;
  logic [31:0]      secs, ck_seconds;
  logic [16:0]      ck_sod;
  logic [4:0]       ck_hour;
  logic [5:0]       ck_minute, ck_second;
  logic [21:0]      cal_jd;
  logic [8:0]       cal_doy;
  logic [4:0]       cal_day;
  logic [3:0]       cal_month;
  logic [11:0]      cal_year;
  logic [2:0]       cal_wd;

  esc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .en_o        (en)
  );

  esc_daycnt u_daycnt (
    .clk_i        (clk_i),
    .en_i         (en),
    .op_i         (op_i),
    .seconds_in_i (seconds_in_i),
    .day_in_i     (day_in_i),
    .month_in_i   (month_in_i),
    .year_in_i    (year_in_i),
    .doy_in_i     (doy_in_i),
    .days_o       (days),
    .err_o        (dc_err),
    .secs_o       (secs),
    .from_sec_o   (from_sec)
  );

  esc_clock #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_clock (
    .clk_i      (clk_i),
    .en_i       (en),
    .days_i     (days),
    .secs_i     (secs),
    .from_sec_i (from_sec),
    .err_i      (dc_err),
    .seconds_o  (ck_seconds),
    .sod_o      (ck_sod),
    .hour_o     (ck_hour),
    .minute_o   (ck_minute),
    .second_o   (ck_second),
    .err_o      (ck_err)
  );

  esc_calendar u_calendar (
    .clk_i          (clk_i),
    .en_i           (en),
    .days_i         (days),
    .julian_day_o   (cal_jd),
    .day_of_year_o  (cal_doy),
    .day_of_month_o (cal_day),
    .month_o        (cal_month),
    .year_o         (cal_year),
    .weekday_o      (cal_wd)
  );

  // stage 8: result register, every field but the error flag cleared on a range error
  logic [31:0] seconds_q, seconds_d;
  logic [21:0] jd_q, jd_d;
  logic [16:0] sod_q, sod_d;
  logic [8:0]  doy_q, doy_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [11:0] year_q, year_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [2:0]  wd_q, wd_d;
  logic        err_q, err_d;

  always_comb begin
    err_d     = ck_err;
    seconds_d = ck_err ? '0 : ck_seconds;
    jd_d      = ck_err ? '0 : cal_jd;
    sod_d     = ck_err ? '0 : ck_sod;
    doy_d     = ck_err ? '0 : cal_doy;
    day_d     = ck_err ? '0 : cal_day;
    month_d   = ck_err ? '0 : cal_month;
    year_d    = ck_err ? '0 : cal_year;
    hour_d    = ck_err ? '0 : ck_hour;
    minute_d  = ck_err ? '0 : ck_minute;
    second_d  = ck_err ? '0 : ck_second;
    wd_d      = ck_err ? '0 : cal_wd;
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      seconds_q <= seconds_d;
      jd_q      <= jd_d;
      sod_q     <= sod_d;
      doy_q     <= doy_d;
      day_q     <= day_d;
      month_q   <= month_d;
      year_q    <= year_d;
      hour_q    <= hour_d;
      minute_q  <= minute_d;
      second_q  <= second_d;
      wd_q      <= wd_d;
      err_q     <= err_d;
    end
  end

  assign seconds_o       = seconds_q;
  assign julian_day_o    = jd_q;
  assign second_of_day_o = sod_q;
  assign day_of_year_o   = doy_q;
  assign day_of_month_o  = day_q;
  assign month_o         = month_q;
  assign year_o          = year_q;
  assign hour_o          = hour_q;
  assign minute_o        = minute_q;
  assign second_o        = second_q;
  assign weekday_o       = wd_q;
  assign range_error_o   = err_q;

  `ESC_ASSERT_IMPLY(a_err_zeroes, out_valid_o && range_error_o, seconds_o == '0 && julian_day_o == '0 && second_of_day_o == '0 && day_of_year_o == '0 && month_o == '0 && year_o == '0 && weekday_o == '0, "error result carries nonzero fields")
  `ESC_ASSERT_IMPLY(a_tod_match, out_valid_o && !range_error_o, second_of_day_o == 17'(hour_o) * 17'd3600 + 17'(minute_o) * 17'd60 + 17'(second_o), "time of day split mismatch")
  `ESC_ASSERT_IMPLY(a_date_sane, out_valid_o && !range_error_o, day_of_month_o != '0 && month_o != '0 && month_o <= 4'd12, "calendar date out of range")
  `ESC_ASSERT_NEXT(a_full_stall, !in_ready_o, out_valid_o, "input stalled without a held result")

endmodule

/* hdl/esc_ctrl.sv */
// Stage valid bits and per-stage load enables of the pipeline.
module esc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output esc_pkg::stage_en_t  en_o
);
  import esc_pkg::*;

  stage_en_t vld_q, vld_d, en;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d    = vld_q;
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = en;
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NumStages-1];

endmodule

/* hdl/esc_daycnt.sv */
// Stages 1-2: request decode and day count since 1970-01-01.
module esc_daycnt (
  input  logic                      clk_i,
  input  esc_pkg::stage_en_t        en_i,
  input  logic [1:0]                op_i,
  input  logic [31:0]               seconds_in_i,
  input  logic [4:0]                day_in_i,
  input  logic [3:0]                month_in_i,
  input  logic [11:0]               year_in_i,
  input  logic [8:0]                doy_in_i,
  output logic [esc_pkg::DaysW-1:0] days_o,
  output logic                      err_o,
  output logic [31:0]               secs_o,
  output logic                      from_sec_o
);
  import esc_pkg::*;

  // seconds / 86400 == (seconds >> 7) / 675, exact by reciprocal for 25-bit values
  localparam logic [25:0] DivMul   = 26'd50903317;
  localparam logic [11:0] YearMin  = 12'd1970;
  localparam logic [11:0] YearMax  = 12'd2106;
  localparam logic [12:0] BaseYear = 13'd1968;

  // stage 1
  logic              from_sec, bad;
  logic [12:0]       y_adj, yy;
  logic [3:0]        m_adj, mp;
  logic [7:0]        k;
  logic signed [10:0] off;
  logic [50:0]       div_prod;

  logic              s1_from_sec_q, s1_err_q;
  logic [7:0]        s1_k_q;
  logic [8:0]        s1_dy_q;
  logic signed [10:0] s1_off_q;
  logic [DaysW-1:0]  s1_quo_q;
  logic [31:0]       s1_secs_q;

  always_comb begin
    from_sec = 1'b0;
    bad      = !(year_in_i inside {[YearMin:YearMax]});
    y_adj    = {1'b0, year_in_i};
    m_adj    = 4'd1;
    off      = '0;
    case (op_i)
      OP_FROM_SECONDS: begin
        from_sec = 1'b1;
        bad      = 1'b0;
      end
      OP_FROM_DATE: begin
        off = $signed({6'b0, day_in_i}) - 11'sd1;
        // month 0 is December before, 13..15 run into the next year
        if (month_in_i == 4'd0) begin
          y_adj = {1'b0, year_in_i} - 13'd1;
          m_adj = 4'd12;
        end else if (month_in_i > 4'd12) begin
          y_adj = {1'b0, year_in_i} + 13'd1;
          m_adj = month_in_i - 4'd12;
        end else begin
          m_adj = month_in_i;
        end
      end
      OP_FROM_YDAY: begin
        off = $signed({2'b0, doy_in_i}) - 11'sd1;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // March-based year: Jan and Feb belong to the year before
    if (m_adj <= 4'd2) begin
      yy = y_adj - 13'd1;
      mp = m_adj + 4'd9;
    end else begin
      yy = y_adj;
      mp = m_adj - 4'd3;
    end
    k        = 8'(yy - BaseYear);
    div_prod = 51'(seconds_in_i[31:7]) * 51'(DivMul);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_from_sec_q <= from_sec;
      s1_err_q      <= bad;
      s1_k_q        <= k;
      s1_dy_q       <= month_start(mp);
      s1_off_q      <= off;
      s1_quo_q      <= div_prod[50:35];
      s1_secs_q     <= seconds_in_i;
    end
  end

  // stage 2: days = seconds quotient, or 365k + k/4 - (2100 skip) + month offset + day offset - 671
  logic [17:0]      sum;
  logic [DaysW-1:0] days_d;
  logic             err_d;
  logic [DaysW-1:0] s2_days_q;
  logic             s2_err_q, s2_from_sec_q;
  logic [31:0]      s2_secs_q;

  always_comb begin
    sum = 18'(s1_k_q) * 18'd365 + 18'(s1_k_q >> 2) - 18'(s1_k_q >= 8'd132)
        + 18'(s1_dy_q) + {{7{s1_off_q[10]}}, s1_off_q} - 18'd671;
    days_d = s1_from_sec_q ? s1_quo_q : sum[DaysW-1:0];
    err_d  = s1_err_q || (!s1_from_sec_q && sum[17]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_days_q     <= days_d;
      s2_err_q      <= err_d;
      s2_secs_q     <= s1_secs_q;
      s2_from_sec_q <= s1_from_sec_q;
    end
  end

  assign days_o     = s2_days_q;
  assign err_o      = s2_err_q;
  assign secs_o     = s2_secs_q;
  assign from_sec_o = s2_from_sec_q;

endmodule

/* hdl/esc_clock.sv */
// Stages 3-7: instant in seconds, range check and time of day.
module esc_clock #(
  parameter int SECONDS_WIDTH = esc_pkg::SecondsWidthDef
) (
  input  logic                      clk_i,
  input  esc_pkg::stage_en_t        en_i,
  input  logic [esc_pkg::DaysW-1:0] days_i,
  input  logic [31:0]               secs_i,
  input  logic                      from_sec_i,
  input  logic                      err_i,
  output logic [31:0]               seconds_o,
  output logic [16:0]               sod_o,
  output logic [4:0]                hour_o,
  output logic [5:0]                minute_o,
  output logic [5:0]                second_o,
  output logic                      err_o
);
  import esc_pkg::*;

  localparam logic [17:0] HourMul = 18'd149131; // ceil(2^29 / 3600)
  localparam logic [12:0] MinMul  = 13'd4370;   // ceil(2^18 / 60)

  // stage 3
  logic [32:0] s3_prod_q;
  logic [31:0] s3_secs_q;
  logic        s3_from_sec_q, s3_err_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_prod_q     <= 33'(days_i) * 33'd86400;
      s3_secs_q     <= secs_i;
      s3_from_sec_q <= from_sec_i;
      s3_err_q      <= err_i;
    end
  end

  // stage 4
  logic        ovf;
  logic [31:0] sod_full;
  logic [31:0] s4_seconds_q;
  logic [16:0] s4_sod_q;
  logic        s4_err_q;

  always_comb begin
    ovf      = !s3_from_sec_q && ((s3_prod_q >> SECONDS_WIDTH) != '0);
    sod_full = s3_secs_q - s3_prod_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_seconds_q <= s3_from_sec_q ? s3_secs_q : s3_prod_q[31:0];
      s4_sod_q     <= s3_from_sec_q ? sod_full[16:0] : '0;
      s4_err_q     <= s3_err_q || ovf;
    end
  end

  // stage 5
  logic [34:0] hprod;
  logic [4:0]  s5_hour_q;
  logic [16:0] s5_sod_q;
  logic [31:0] s5_seconds_q;
  logic        s5_err_q;

  assign hprod = 35'(s4_sod_q) * 35'(HourMul);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_hour_q    <= hprod[33:29];
      s5_sod_q     <= s4_sod_q;
      s5_seconds_q <= s4_seconds_q;
      s5_err_q     <= s4_err_q;
    end
  end

  // stage 6
  logic [11:0] s6_rem_q;
  logic [4:0]  s6_hour_q;
  logic [16:0] s6_sod_q;
  logic [31:0] s6_seconds_q;
  logic        s6_err_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_rem_q     <= 12'(s5_sod_q - 17'(s5_hour_q) * 17'd3600);
      s6_hour_q    <= s5_hour_q;
      s6_sod_q     <= s5_sod_q;
      s6_seconds_q <= s5_seconds_q;
      s6_err_q     <= s5_err_q;
    end
  end

  // stage 7
  logic [24:0] mprod;
  logic [5:0]  s7_minute_q;
  logic [11:0] s7_rem_q;
  logic [4:0]  s7_hour_q;
  logic [16:0] s7_sod_q;
  logic [31:0] s7_seconds_q;
  logic        s7_err_q;

  assign mprod = 25'(s6_rem_q) * 25'(MinMul);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_minute_q  <= mprod[23:18];
      s7_rem_q     <= s6_rem_q;
      s7_hour_q    <= s6_hour_q;
      s7_sod_q     <= s6_sod_q;
      s7_seconds_q <= s6_seconds_q;
      s7_err_q     <= s6_err_q;
    end
  end

  assign seconds_o = s7_seconds_q;
  assign sod_o     = s7_sod_q;
  assign hour_o    = s7_hour_q;
  assign minute_o  = s7_minute_q;
  assign second_o  = 6'(s7_rem_q - 12'(s7_minute_q) * 12'd60);
  assign err_o     = s7_err_q;

endmodule

/* hdl/esc_calendar.sv */
// Stages 3-7: Gregorian date, day of year, Julian day and weekday.
module esc_calendar (
  input  logic                      clk_i,
  input  esc_pkg::stage_en_t        en_i,
  input  logic [esc_pkg::DaysW-1:0] days_i,
  output logic [21:0]               julian_day_o,
  output logic [8:0]                day_of_year_o,
  output logic [4:0]                day_of_month_o,
  output logic [3:0]                month_o,
  output logic [11:0]               year_o,
  output logic [2:0]                weekday_o
);
  import esc_pkg::*;

  localparam logic [17:0] CycMul   = 18'd183735; // ceil(2^28 / 1461)
  localparam logic [11:0] BaseYear = 12'd1968;

  // stage 3: days since 1968-03-01, with a phantom Feb 29 2100 so that
  // four-year cycles stay regular
  logic [16:0] e_d;
  logic [17:0] wt;
  logic [5:0]  wsum;
  logic [16:0] s3_e_q;
  logic [5:0]  s3_wsum_q;
  logic [21:0] s3_jd_q;

  always_comb begin
    e_d  = 17'(days_i) + 17'd671 + 17'(days_i >= 16'd47541);
    // weekday = (days + 4) mod 7; 8 == 1 mod 7, so octal digits add up
    wt   = 18'(days_i) + 18'd4;
    wsum = 6'(wt[2:0]) + 6'(wt[5:3]) + 6'(wt[8:6]) + 6'(wt[11:9])
         + 6'(wt[14:12]) + 6'(wt[17:15]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_e_q    <= e_d;
      s3_wsum_q <= wsum;
      s3_jd_q   <= 22'(days_i) + 22'd2440588;
    end
  end

  // stage 4: four-year cycle index
  logic [34:0] qprod;
  logic [3:0]  w2;
  logic [5:0]  s4_q4_q;
  logic [16:0] s4_e_q;
  logic [2:0]  s4_wd_q;
  logic [21:0] s4_jd_q;

  always_comb begin
    qprod = 35'(s3_e_q) * 35'(CycMul);
    w2    = 4'(s3_wsum_q[5:3]) + 4'(s3_wsum_q[2:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_q4_q <= qprod[33:28];
      s4_e_q  <= s3_e_q;
      s4_wd_q <= (w2 >= 4'd7) ? 3'(w2 - 4'd7) : w2[2:0];
      s4_jd_q <= s3_jd_q;
    end
  end

  // stage 5: day within the cycle
  logic [10:0] s5_r_q;
  logic [5:0]  s5_q4_q;
  logic [2:0]  s5_wd_q;
  logic [21:0] s5_jd_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_r_q  <= 11'(s4_e_q - 17'(s4_q4_q) * 17'd1461);
      s5_q4_q <= s4_q4_q;
      s5_wd_q <= s4_wd_q;
      s5_jd_q <= s4_jd_q;
    end
  end

  // stage 6: year in the cycle; the last cycle day stays in year three
  logic [1:0]  yc;
  logic [8:0]  s6_x_q;
  logic [11:0] s6_ym_q;
  logic [2:0]  s6_wd_q;
  logic [21:0] s6_jd_q;

  assign yc = 2'(s5_r_q >= 11'd365) + 2'(s5_r_q >= 11'd730) + 2'(s5_r_q >= 11'd1095);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_x_q  <= 9'(s5_r_q - 11'(yc) * 11'd365);
      s6_ym_q <= BaseYear + (12'(s5_q4_q) << 2) + 12'(yc);
      s6_wd_q <= s5_wd_q;
      s6_jd_q <= s5_jd_q;
    end
  end

  // stage 7: month, day, day of year and year from the March-based day
  logic [3:0]  mp;
  logic        jan_feb, leap;
  logic [8:0]  doy;

  always_comb begin
    mp = '0;
    for (int i = 1; i < 12; i++) begin
      if (s6_x_q >= month_start(4'(i))) begin
        mp = mp + 4'd1;
      end
    end
    jan_feb = (mp >= 4'd10);
    leap    = (s6_ym_q[1:0] == 2'd0) && (s6_ym_q != 12'd2100);
    doy     = jan_feb ? s6_x_q - 9'd305 : s6_x_q + 9'd60 + 9'(leap);
  end

  logic [21:0] s7_jd_q;
  logic [8:0]  s7_doy_q;
  logic [4:0]  s7_day_q;
  logic [3:0]  s7_month_q;
  logic [11:0] s7_year_q;
  logic [2:0]  s7_wd_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_jd_q    <= s6_jd_q;
      s7_doy_q   <= doy;
      s7_day_q   <= 5'(s6_x_q - month_start(mp) + 9'd1);
      s7_month_q <= jan_feb ? mp - 4'd9 : mp + 4'd3;
      s7_year_q  <= s6_ym_q + 12'(jan_feb);
      s7_wd_q    <= s6_wd_q;
    end
  end

  assign julian_day_o   = s7_jd_q;
  assign day_of_year_o  = s7_doy_q;
  assign day_of_month_o = s7_day_q;
  assign month_o        = s7_month_q;
  assign year_o         = s7_year_q;
  assign weekday_o      = s7_wd_q;

endmodule
